### src/attitude_quaternion_integrator_assert.svh
// Assertion macros for the attitude integrator.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ATTITUDE_QUATERNION_INTEGRATOR_ASSERT_SVH
`define ATTITUDE_QUATERNION_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define AQI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aqi: same-cycle check failed");
`define AQI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aqi: next-cycle check failed");
`else
`define AQI_ASSERT_IMP(lbl, ante, cons)
`define AQI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/aqi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aqi_pkg;

  localparam int QF = 30;              // quaternion fraction bits
  localparam int VF = 24;              // rate / error fraction bits
  localparam int HALF_SH = QF - VF - 1;
  localparam int HALF_L = (HALF_SH > 0) ? HALF_SH : 0;
  localparam int HALF_R = (HALF_SH < 0) ? -HALF_SH : 0;
  localparam int INV_W = 2 * QF + 1;   // width of floor(2^2F / n)
  localparam int LO_W = 31;            // low slice of inv per partial product
  localparam int CW = 6;               // step counter width

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< QF;
  localparam logic [31:0] TS_RESET = 32'd4294967;

  localparam logic [1:0] MODE_PROP = 2'd0;
  localparam logic [1:0] MODE_CORR = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam logic [CW-1:0] LAST_TERM = CW'(3);
  localparam logic [CW-1:0] LAST_SQRT = CW'(31);
  localparam logic [CW-1:0] LAST_DIV = CW'(INV_W - 1);

  typedef logic signed [97:0] wide_t;
  localparam wide_t MAXW = 98'sd2147483647;
  localparam wide_t MINW = -98'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_HALF, S_TMUL, S_TACC, S_CEND, S_IADD, S_SQM, S_SQA,
    S_SQI, S_SQS, S_DVI, S_DVS, S_NML, S_NMH, S_NFIN, S_COMMIT, S_PUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_HALF, OP_TMUL, OP_TACC, OP_CEND, OP_IADD, OP_SQM,
    OP_SQA, OP_SQI, OP_SQS, OP_DVI, OP_DVS, OP_NML, OP_NMH, OP_NFIN,
    OP_COMMIT, OP_PUT
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [CW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       nzero;
  } dp_stat_t;

  typedef struct packed {
    logic       en;
    logic       neg;
    logic [1:0] qi;
    logic [1:0] vi;
  } term_t;

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > MAXW) r = 32'sh7fffffff;
    else if (v < MINW) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] half_err(input logic signed [31:0] v);
    wide_t w;
    w = (wide_t'(v) <<< HALF_L) >>> HALF_R;
    return sat32(w);
  endfunction

  // Product terms: m1 = 0 gives q[qi]*v[vi] for the rate product,
  // m1 = 1 gives d[j]*q[qi] for the correction product (j = n[1:0]).
  function automatic term_t term_info(input logic m1, input logic [3:0] n);
    term_t t;
    case ({m1, n})
      5'd0:  t = '{1'b1, 1'b1, 2'd1, 2'd0};
      5'd1:  t = '{1'b1, 1'b1, 2'd2, 2'd1};
      5'd2:  t = '{1'b1, 1'b1, 2'd3, 2'd2};
      5'd4:  t = '{1'b1, 1'b0, 2'd0, 2'd0};
      5'd5:  t = '{1'b1, 1'b0, 2'd2, 2'd2};
      5'd6:  t = '{1'b1, 1'b1, 2'd3, 2'd1};
      5'd8:  t = '{1'b1, 1'b0, 2'd0, 2'd1};
      5'd9:  t = '{1'b1, 1'b0, 2'd3, 2'd0};
      5'd10: t = '{1'b1, 1'b1, 2'd1, 2'd2};
      5'd12: t = '{1'b1, 1'b0, 2'd0, 2'd2};
      5'd13: t = '{1'b1, 1'b0, 2'd1, 2'd1};
      5'd14: t = '{1'b1, 1'b1, 2'd2, 2'd0};
      5'd16: t = '{1'b1, 1'b0, 2'd0, 2'd0};
      5'd17: t = '{1'b1, 1'b1, 2'd1, 2'd0};
      5'd18: t = '{1'b1, 1'b1, 2'd2, 2'd0};
      5'd19: t = '{1'b1, 1'b1, 2'd3, 2'd0};
      5'd20: t = '{1'b1, 1'b0, 2'd1, 2'd0};
      5'd21: t = '{1'b1, 1'b0, 2'd0, 2'd0};
      5'd22: t = '{1'b1, 1'b0, 2'd3, 2'd0};
      5'd23: t = '{1'b1, 1'b1, 2'd2, 2'd0};
      5'd24: t = '{1'b1, 1'b0, 2'd2, 2'd0};
      5'd25: t = '{1'b1, 1'b1, 2'd3, 2'd0};
      5'd26: t = '{1'b1, 1'b0, 2'd0, 2'd0};
      5'd27: t = '{1'b1, 1'b0, 2'd1, 2'd0};
      5'd28: t = '{1'b1, 1'b0, 2'd3, 2'd0};
      5'd29: t = '{1'b1, 1'b0, 2'd2, 2'd0};
      5'd30: t = '{1'b1, 1'b1, 2'd1, 2'd0};
      5'd31: t = '{1'b1, 1'b0, 2'd0, 2'd0};
      default: t = '{1'b0, 1'b0, 2'd0, 2'd0};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

### src/aqi_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aqi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] load_w;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  modport source (output valid, mode, load_w, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, mode, load_w, vec_x, vec_y, vec_z, output ready);
endinterface

interface aqi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic               norm_failed;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, norm_failed,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, norm_failed,
                output ready);
endinterface
`default_nettype wire

### src/aqi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module aqi_datapath import aqi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] load_w,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] vec_z,
  output logic signed [31:0]      quat_w,
  output logic signed [31:0]      quat_x,
  output logic signed [31:0]      quat_y,
  output logic signed [31:0]      quat_z,
  output logic                    norm_failed
);

  logic [31:0]        time_step;
  logic [1:0]         mode_r;
  logic signed [31:0] q [4];
  logic signed [31:0] t [4];
  logic signed [31:0] u [4];
  logic signed [31:0] v [3];
  logic signed [31:0] out_q [4];
  logic               failed;
  logic               out_failed;
  logic signed [34:0] acc;
  logic signed [65:0] p;
  logic signed [65:0] plo;
  logic [63:0]        s;
  logic [63:0]        rem;
  logic [63:0]        res;
  logic [31:0]        drem;
  logic [INV_W-1:0]   inv;

  logic               corr;
  term_t              term;
  logic [1:0]         q_ra;
  logic [1:0]         t_ra;
  logic signed [31:0] q_rd;
  logic signed [31:0] t_rd;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic signed [31:0] p_term;
  logic signed [31:0] acc_sat;
  logic signed [34:0] acc_base;
  logic signed [34:0] acc_new;
  logic [64:0]        s_sum;
  logic [63:0]        sq_bit;
  logic [64:0]        sq_try;
  logic [32:0]        dsh;

  assign corr = (mode_r == MODE_CORR);
  assign term = term_info(corr, cmd.idx[3:0]);
  assign q_rd = q[q_ra];
  assign t_rd = t[t_ra];
  assign acc_sat = sat32(wide_t'(acc));

  // operand select for the shared multiplier
  always_comb begin
    q_ra = cmd.idx[3:2];
    t_ra = cmd.idx[1:0];
    ma = 33'(t_rd);
    mb = 33'(t_rd);
    case (cmd.op)
      OP_TMUL: begin
        q_ra = term.qi;
        if (corr) begin
          ma = 33'(t_rd);
          mb = 33'(q_rd);
        end else begin
          ma = 33'(q_rd);
          mb = 33'(v[term.vi]);
        end
      end
      OP_CEND: begin
        ma = 33'(acc_sat);
        mb = signed'({1'b0, time_step});
      end
      OP_NML: mb = signed'(33'(inv[LO_W-1:0]));
      OP_NMH: mb = signed'(33'(inv[INV_W-1:LO_W]));
      default: begin
        ma = 33'(t_rd);
        mb = 33'(t_rd);
      end
    endcase
  end

  assign prod = ma * mb;

  assign p_term = corr ? sat32(wide_t'(p) >>> QF) : sat32(wide_t'(p) >>> VF);
  assign acc_base = (cmd.idx[1:0] == 2'd0) ? 35'sd0 : acc;
  always_comb begin
    if (!term.en) acc_new = acc_base;
    else if (term.neg) acc_new = acc_base - 35'(p_term);
    else acc_new = acc_base + 35'(p_term);
  end

  assign s_sum = {1'b0, ((cmd.idx[1:0] == 2'd0) ? 64'd0 : s)} + {1'b0, p[63:0]};
  assign sq_bit = 64'h4000_0000_0000_0000 >> {cmd.idx[4:0], 1'b0};
  assign sq_try = {1'b0, res} + {1'b0, sq_bit};
  assign dsh = {drem, (cmd.idx == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TS_RESET;
      q[0] <= ONE_Q;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
    end else begin
      if (cfg_we) time_step <= cfg_data;
      case (cmd.op)
        OP_LATCH: begin
          mode_r <= mode;
          v[0] <= vec_x;
          v[1] <= vec_y;
          v[2] <= vec_z;
          failed <= 1'b0;
          if (mode == MODE_LOAD) begin
            q[0] <= load_w;
            q[1] <= vec_x;
            q[2] <= vec_y;
            q[3] <= vec_z;
          end
        end
        OP_HALF: begin
          t[0] <= ONE_Q;
          for (int i = 1; i < 4; i++) t[i] <= half_err(v[i-1]);
        end
        OP_TMUL, OP_SQM, OP_NML: p <= prod;
        OP_TACC: acc <= acc_new;
        OP_CEND: begin
          p <= prod;
          u[cmd.idx[3:2]] <= acc_sat;
        end
        OP_IADD: t[cmd.idx[3:2]] <= sat32(wide_t'(q_rd) + (wide_t'(p) >>> 33));
        OP_SQA: s <= s_sum[64] ? '1 : s_sum[63:0];
        OP_SQI: begin
          rem <= s;
          res <= '0;
        end
        OP_SQS: begin
          if ({1'b0, rem} >= sq_try) begin
            rem <= rem - sq_try[63:0];
            res <= (res >> 1) + sq_bit;
          end else begin
            res <= res >> 1;
          end
        end
        OP_DVI: drem <= '0;
        OP_DVS: begin
          if (dsh >= {1'b0, res[31:0]}) begin
            drem <= 32'(dsh - {1'b0, res[31:0]});
            inv <= {inv[INV_W-2:0], 1'b1};
          end else begin
            drem <= dsh[31:0];
            inv <= {inv[INV_W-2:0], 1'b0};
          end
        end
        OP_NMH: begin
          plo <= p;
          p <= prod;
        end
        OP_NFIN: t[cmd.idx[1:0]] <=
            sat32((wide_t'(plo) + (wide_t'(p) <<< LO_W)) >>> QF);
        OP_COMMIT: begin
          for (int i = 0; i < 4; i++) q[i] <= corr ? u[i] : t[i];
          failed <= !corr && (res == '0);
        end
        OP_PUT: begin
          for (int i = 0; i < 4; i++) out_q[i] <= q[i];
          out_failed <= failed;
        end
        default: ;
      endcase
    end
  end

  assign stat.mode = mode_r;
  assign stat.nzero = (res == '0);

  assign quat_w = out_q[0];
  assign quat_x = out_q[1];
  assign quat_y = out_q[2];
  assign quat_z = out_q[3];
  assign norm_failed = out_failed;

endmodule
`default_nettype wire

### src/aqi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module aqi_ctrl import aqi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          put_ok;

  assign put_ok = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (state == S_PUT && put_ok) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DISP;
      S_DISP: begin
        cnt_next = '0;
        if (stat.mode == MODE_PROP) state_next = S_TMUL;
        else if (stat.mode == MODE_CORR) state_next = S_HALF;
        else state_next = S_PUT;
      end
      S_HALF: state_next = S_SQM;
      S_TMUL: state_next = S_TACC;
      S_TACC: begin
        if (cnt[1:0] == 2'd3) state_next = S_CEND;
        else begin
          cnt_next = cnt + 1'b1;
          state_next = S_TMUL;
        end
      end
      S_CEND: begin
        if (stat.mode == MODE_PROP) state_next = S_IADD;
        else if (cnt[3:2] == 2'd3) state_next = S_COMMIT;
        else begin
          cnt_next = cnt + 1'b1;
          state_next = S_TMUL;
        end
      end
      S_IADD: begin
        cnt_next = cnt + 1'b1;
        state_next = S_TMUL;
        if (cnt[3:2] == 2'd3) begin
          cnt_next = '0;
          state_next = S_SQM;
        end
      end
      S_SQM: state_next = S_SQA;
      S_SQA: begin
        if (cnt == LAST_TERM) state_next = S_SQI;
        else begin
          cnt_next = cnt + 1'b1;
          state_next = S_SQM;
        end
      end
      S_SQI: begin
        cnt_next = '0;
        state_next = S_SQS;
      end
      S_SQS: begin
        if (cnt == LAST_SQRT) state_next = S_DVI;
        else cnt_next = cnt + 1'b1;
      end
      S_DVI: begin
        cnt_next = '0;
        state_next = stat.nzero ? S_COMMIT : S_DVS;
      end
      S_DVS: begin
        if (cnt == LAST_DIV) begin
          cnt_next = '0;
          state_next = S_NML;
        end else cnt_next = cnt + 1'b1;
      end
      S_NML: state_next = S_NMH;
      S_NMH: state_next = S_NFIN;
      S_NFIN: begin
        if (cnt == LAST_TERM) begin
          cnt_next = '0;
          state_next = (stat.mode == MODE_PROP) ? S_COMMIT : S_TMUL;
        end else begin
          cnt_next = cnt + 1'b1;
          state_next = S_NML;
        end
      end
      S_COMMIT: state_next = S_PUT;
      S_PUT: if (put_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.idx = cnt;
    case (state)
      S_IDLE:   cmd.op = in_valid ? OP_LATCH : OP_NONE;
      S_HALF:   cmd.op = OP_HALF;
      S_TMUL:   cmd.op = OP_TMUL;
      S_TACC:   cmd.op = OP_TACC;
      S_CEND:   cmd.op = OP_CEND;
      S_IADD:   cmd.op = OP_IADD;
      S_SQM:    cmd.op = OP_SQM;
      S_SQA:    cmd.op = OP_SQA;
      S_SQI:    cmd.op = OP_SQI;
      S_SQS:    cmd.op = OP_SQS;
      S_DVI:    cmd.op = OP_DVI;
      S_DVS:    cmd.op = OP_DVS;
      S_NML:    cmd.op = OP_NML;
      S_NMH:    cmd.op = OP_NMH;
      S_NFIN:   cmd.op = OP_NFIN;
      S_COMMIT: cmd.op = OP_COMMIT;
      S_PUT:    cmd.op = put_ok ? OP_PUT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

### src/attitude_quaternion_integrator.sv
// Attitude quaternion integrator, Q2.30 state.
// in_ch (valid/ready): one request carries mode, load_w and vec_x/y/z.
//   Mode 0 propagates with a body rate, mode 1 applies an attitude
//   correction, mode 2 loads the quaternion, mode 3 returns the state.
// out_ch (valid/ready): one result per request, quat_w..z and norm_failed.
// cfg_we/cfg_data: writes time_step (unsigned Q0.32 s); write only when idle.
// For mode 0 a zero norm skips the divide and the scaling. One request
//   is in flight at a time; in_ch goes ready again at the clock edge that
//   loads the result into the output register.
// The work runs through the 32-step bit-serial square root, the 61-step
//   restoring divider and the single shared 33x33 multiplier (a multiply
//   state and an accumulate state per product term).
// A finished result sits in the output register; the next request is
//   accepted while it waits. If out_ch stalls, the following result holds
//   in the state register until the output register frees up.
// Reset (rst, synchronous, active high): state becomes the identity
//   quaternion, time_step about 1 ms, out_ch empty.
`timescale 1ns / 1ps
`default_nettype none
`include "attitude_quaternion_integrator_assert.svh"
module attitude_quaternion_integrator import aqi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  aqi_in_if.sink           in_ch,
  aqi_out_if.source        out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks the product terms, square root, divide and scaling
  aqi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // state, working registers, shared multiplier and output register
  aqi_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mode        (in_ch.mode),
    .load_w      (in_ch.load_w),
    .vec_x       (in_ch.vec_x),
    .vec_y       (in_ch.vec_y),
    .vec_z       (in_ch.vec_z),
    .quat_w      (out_ch.quat_w),
    .quat_x      (out_ch.quat_x),
    .quat_y      (out_ch.quat_y),
    .quat_z      (out_ch.quat_z),
    .norm_failed (out_ch.norm_failed)
  );

  // a request is worked on alone: no second accept right after one
  `AQI_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // the output register is only loaded when it is free
  `AQI_ASSERT_IMP(a_put_when_free, cmd.op == OP_PUT, !out_ch.valid || out_ch.ready)
  // a load of the output register shows up as a valid result
  `AQI_ASSERT_NXT(a_put_shows, cmd.op == OP_PUT, out_ch.valid)

endmodule
`default_nettype wire
